FILE: src/rwhs_pkg.sv
// shared types and constants for the ray wall hit selector
package rwhs_pkg;

  // fixed point format and block size in pixels
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned BLOCK_SIZE = 64;
  localparam int unsigned BLK_SHIFT  = $clog2(BLOCK_SIZE) + FRAC_BITS;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned MAG_W   = 25;
  localparam int unsigned SQ_W    = 2 * MAG_W;
  localparam int unsigned SUM_W   = SQ_W + 1;
  localparam int unsigned RAD_W   = 52;
  localparam int unsigned ROOT_W  = RAD_W / 2;
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned DIST_W  = 25;
  localparam int unsigned OFS_W   = 15;
  localparam int unsigned CELL_W  = 12;
  localparam int unsigned QUOT_W  = COORD_W - BLK_SHIFT;

  // output queue
  localparam int unsigned OQ_DEPTH = 32;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);

  // request kinds
  localparam logic REQ_MAP_WRITE = 1'b0;
  localparam logic REQ_RAY       = 1'b1;

  // register indexes
  localparam logic [2:0] REG_PLAYER_X = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y = 3'd1;
  localparam logic [2:0] REG_MAP_COLS = 3'd2;
  localparam logic [2:0] REG_MAP_ROWS = 3'd3;

  typedef enum logic [2:0] {
    SIDE_TOP    = 3'd0,
    SIDE_BOTTOM = 3'd1,
    SIDE_RIGHT  = 3'd2,
    SIDE_LEFT   = 3'd3,
    SIDE_DOOR   = 3'd4
  } side_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [OFS_W-1:0]   ofs;
    side_e              side;
  } meta_t;

  typedef struct packed {
    logic [DIST_W-1:0] hit_dist;
    meta_t             meta;
  } result_t;

endpackage

FILE: src/rwhs_ram.sv
// generic single write port ram with registered read
module rwhs_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/rwhs_sqrt.sv
// pipelined integer square root, one result bit per stage, with side payload
module rwhs_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [rwhs_pkg::RAD_W-1:0]     rad_i,
  input  rwhs_pkg::meta_t                meta_i,
  output logic                           valid_o,
  output logic [rwhs_pkg::ROOT_W-1:0]    root_o,
  output rwhs_pkg::meta_t                meta_o
);

  localparam int unsigned STEPS = rwhs_pkg::ROOT_W;

  logic                          valid_q [STEPS+1];
  logic [rwhs_pkg::RAD_W-1:0]    rad_q   [STEPS+1];
  logic [rwhs_pkg::REM_W-1:0]    rem_q   [STEPS+1];
  logic [rwhs_pkg::ROOT_W-1:0]   root_q  [STEPS+1];
  rwhs_pkg::meta_t               meta_q  [STEPS+1];

  assign valid_q[0] = valid_i;
  assign rad_q[0]   = rad_i;
  assign rem_q[0]   = '0;
  assign root_q[0]  = '0;
  assign meta_q[0]  = meta_i;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [rwhs_pkg::REM_W-1:0] rem_sh;
    logic [rwhs_pkg::REM_W-1:0] trial;
    logic                       fits;

    always_comb begin
      rem_sh = {rem_q[i][rwhs_pkg::REM_W-3:0], rad_q[i][rwhs_pkg::RAD_W-1 -: 2]};
      trial  = {root_q[i], 2'b01};
      fits   = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[i+1]  <= rad_q[i] << 2;
      rem_q[i+1]  <= fits ? rem_sh - trial : rem_sh;
      root_q[i+1] <= {root_q[i][rwhs_pkg::ROOT_W-2:0], fits};
      meta_q[i+1] <= meta_q[i];
    end
  end

  assign valid_o = valid_q[STEPS];
  assign root_o  = root_q[STEPS];
  assign meta_o  = meta_q[STEPS];

endmodule

FILE: src/rwhs_oq.sv
// output queue in flops, parts the pipeline from the consumer stall
module rwhs_oq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rwhs_pkg::result_t data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output rwhs_pkg::result_t data_o
);

  rwhs_pkg::result_t                 buf_q [rwhs_pkg::OQ_DEPTH];
  logic [rwhs_pkg::OQ_PTR_W-1:0]     wptr_q, rptr_q;
  logic [rwhs_pkg::OQ_PTR_W:0]       count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      count_q <= count_q + (rwhs_pkg::OQ_PTR_W+1)'(push_i)
                         - (rwhs_pkg::OQ_PTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= data_i;
    end
  end

  assign valid_o = count_q != '0;
  assign data_o  = buf_q[rptr_q];

endmodule

FILE: src/ray_wall_hit_select.sv
// ray wall hit selector top level: distances, choice, door lookup, root, queue
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | in        | in_valid_i/in_stall_o | req_type_i, hit points, cell fields
//  out     | out       | out_valid_o/out_stall_i | distance, point, offset, side
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one request per cycle while in_stall_o is low; out_valid_o rises once a ray request is taken
// and has passed the four front stages, the 26 stage root pipeline and the queue write
// (the door map read overlaps the fourth front stage)
// after reset the door map is swept clear, with in_stall_o high until the sweep is done.
// up to 32 rays may be in flight or queued; in_stall_o rises when that credit runs out
// or the map is being swept, so a stalled consumer holds the input back once 32 rays are outstanding
module ray_wall_hit_select #(
  parameter int unsigned MAP_COLS = 64,
  parameter int unsigned MAP_ROWS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic signed [rwhs_pkg::COORD_W-1:0]  horiz_hit_x_i,
  input  logic signed [rwhs_pkg::COORD_W-1:0]  horiz_hit_y_i,
  input  logic signed [rwhs_pkg::COORD_W-1:0]  vert_hit_x_i,
  input  logic signed [rwhs_pkg::COORD_W-1:0]  vert_hit_y_i,
  input  logic                                 horiz_step_negative_i,
  input  logic                                 vert_step_positive_i,
  input  logic [5:0]                           cell_col_i,
  input  logic [5:0]                           cell_row_i,
  input  logic                                 cell_is_door_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [rwhs_pkg::DIST_W-1:0]          hit_distance_o,
  output logic signed [rwhs_pkg::COORD_W-1:0]  chosen_x_o,
  output logic signed [rwhs_pkg::COORD_W-1:0]  chosen_y_o,
  output logic signed [rwhs_pkg::OFS_W-1:0]    texture_offset_o,
  output logic [2:0]                           wall_side_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [2:0]                           cfg_index_i,
  input  logic [15:0]                          cfg_data_i
);

  localparam int unsigned DEPTH = MAP_ROWS * MAP_COLS;
  localparam int unsigned AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = rwhs_pkg::COORD_W;
  localparam int unsigned MW    = rwhs_pkg::MAG_W;
  localparam int unsigned QW    = rwhs_pkg::QUOT_W;
  localparam int unsigned BS    = rwhs_pkg::BLK_SHIFT;
  localparam int unsigned XW    = rwhs_pkg::CELL_W;

  // configuration
  logic [rwhs_pkg::POS_W-1:0] player_x_q, player_y_q;
  logic [6:0]                 cols_q, rows_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_q <= '0;
      player_y_q <= '0;
      cols_q     <= 7'd64;
      rows_q     <= 7'd64;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rwhs_pkg::REG_PLAYER_X: player_x_q <= cfg_data_i;
        rwhs_pkg::REG_PLAYER_Y: player_y_q <= cfg_data_i;
        rwhs_pkg::REG_MAP_COLS: cols_q     <= cfg_data_i[6:0];
        rwhs_pkg::REG_MAP_ROWS: rows_q     <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // clearing sweep and ray credit
  logic                           clr_busy_q;
  logic [AW-1:0]                  clr_addr_q;
  logic [rwhs_pkg::OQ_PTR_W:0]    credit_q;
  logic                           in_acc, ray_acc, pop;

  assign in_stall_o = clr_busy_q || (credit_q == (rwhs_pkg::OQ_PTR_W+1)'(rwhs_pkg::OQ_DEPTH));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ray_acc    = in_acc && (req_type_i == rwhs_pkg::REQ_RAY);
  assign pop        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      credit_q   <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      credit_q <= credit_q + (rwhs_pkg::OQ_PTR_W+1)'(ray_acc)
                           - (rwhs_pkg::OQ_PTR_W+1)'(pop);
    end
  end

  // stage a: request register
  logic                 a_valid_q, a_type_q, a_hneg_q, a_vpos_q, a_door_q;
  logic signed [CW-1:0] a_hx_q, a_hy_q, a_vx_q, a_vy_q;
  logic [5:0]           a_col_q, a_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    a_type_q <= req_type_i;
    a_hx_q   <= horiz_hit_x_i;
    a_hy_q   <= horiz_hit_y_i;
    a_vx_q   <= vert_hit_x_i;
    a_vy_q   <= vert_hit_y_i;
    a_hneg_q <= horiz_step_negative_i;
    a_vpos_q <= vert_step_positive_i;
    a_col_q  <= cell_col_i;
    a_row_q  <= cell_row_i;
    a_door_q <= cell_is_door_i;
  end

  function automatic logic [MW-1:0] axis_mag(logic signed [CW-1:0] c,
                                             logic [rwhs_pkg::POS_W-1:0] p);
    logic signed [MW:0] d;
    d = {{2{c[CW-1]}}, c} - $signed({2'b00, p, (rwhs_pkg::FRAC_BITS)'(0)});
    return d[MW] ? MW'(-d) : d[MW-1:0];
  endfunction

  // stage b: axis magnitudes
  logic                 b_valid_q, b_type_q, b_hneg_q, b_vpos_q, b_door_q;
  logic signed [CW-1:0] b_hx_q, b_hy_q, b_vx_q, b_vy_q;
  logic [5:0]           b_col_q, b_row_q;
  logic [MW-1:0]        b_mhx_q, b_mhy_q, b_mvx_q, b_mvy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_type_q <= a_type_q;
    b_hx_q   <= a_hx_q;
    b_hy_q   <= a_hy_q;
    b_vx_q   <= a_vx_q;
    b_vy_q   <= a_vy_q;
    b_hneg_q <= a_hneg_q;
    b_vpos_q <= a_vpos_q;
    b_col_q  <= a_col_q;
    b_row_q  <= a_row_q;
    b_door_q <= a_door_q;
    b_mhx_q  <= axis_mag(a_hx_q, player_x_q);
    b_mhy_q  <= axis_mag(a_hy_q, player_y_q);
    b_mvx_q  <= axis_mag(a_vx_q, player_x_q);
    b_mvy_q  <= axis_mag(a_vy_q, player_y_q);
  end

  // stage c: squares
  logic                       c_valid_q, c_type_q, c_hneg_q, c_vpos_q, c_door_q;
  logic signed [CW-1:0]       c_hx_q, c_hy_q, c_vx_q, c_vy_q;
  logic [5:0]                 c_col_q, c_row_q;
  logic [rwhs_pkg::SQ_W-1:0]  c_shx_q, c_shy_q, c_svx_q, c_svy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_type_q <= b_type_q;
    c_hx_q   <= b_hx_q;
    c_hy_q   <= b_hy_q;
    c_vx_q   <= b_vx_q;
    c_vy_q   <= b_vy_q;
    c_hneg_q <= b_hneg_q;
    c_vpos_q <= b_vpos_q;
    c_col_q  <= b_col_q;
    c_row_q  <= b_row_q;
    c_door_q <= b_door_q;
    c_shx_q  <= b_mhx_q * b_mhx_q;
    c_shy_q  <= b_mhy_q * b_mhy_q;
    c_svx_q  <= b_mvx_q * b_mvx_q;
    c_svy_q  <= b_mvy_q * b_mvy_q;
  end

  // stage c logic: choice, offset, cell behind the hit, map access
  logic [rwhs_pkg::SUM_W-1:0]  hsq, vsq, sq_sel;
  logic                        pick_v;
  logic signed [CW-1:0]        rx, ry, oc;
  rwhs_pkg::side_e             side_c;
  logic [CW-1:0]               omag, xmag, ymag;
  logic [rwhs_pkg::OFS_W-1:0]  ofs_c;
  logic signed [XW-1:0]        mx, my;
  logic                        in_range;
  logic [31:0]                 raddr_w, waddr_w;
  logic                        map_we;

  always_comb begin
    hsq    = rwhs_pkg::SUM_W'(c_shx_q) + rwhs_pkg::SUM_W'(c_shy_q);
    vsq    = rwhs_pkg::SUM_W'(c_svx_q) + rwhs_pkg::SUM_W'(c_svy_q);
    pick_v = hsq > vsq;
    if (pick_v) begin
      rx     = c_vx_q;
      ry     = c_vy_q;
      sq_sel = vsq;
      oc     = c_vy_q;
      side_c = c_vpos_q ? rwhs_pkg::SIDE_LEFT : rwhs_pkg::SIDE_RIGHT;
    end else begin
      rx     = c_hx_q;
      ry     = c_hy_q;
      sq_sel = hsq;
      oc     = c_hx_q;
      side_c = c_hneg_q ? rwhs_pkg::SIDE_BOTTOM : rwhs_pkg::SIDE_TOP;
    end
    // remainder and quotient truncate toward zero, so work on magnitudes
    omag  = oc[CW-1] ? CW'(-oc) : oc;
    ofs_c = oc[CW-1] ? rwhs_pkg::OFS_W'(-{1'b0, omag[BS-1:0]})
                     : rwhs_pkg::OFS_W'({1'b0, omag[BS-1:0]});
    xmag  = rx[CW-1] ? CW'(-rx) : rx;
    ymag  = ry[CW-1] ? CW'(-ry) : ry;
    mx    = rx[CW-1] ? -$signed(XW'(xmag[CW-1 -: QW])) : $signed(XW'(xmag[CW-1 -: QW]));
    my    = ry[CW-1] ? -$signed(XW'(ymag[CW-1 -: QW])) : $signed(XW'(ymag[CW-1 -: QW]));
    if (side_c == rwhs_pkg::SIDE_RIGHT) begin
      mx = mx - XW'(1);
    end else if (side_c == rwhs_pkg::SIDE_BOTTOM) begin
      my = my - XW'(1);
    end
    in_range = !mx[XW-1] && !my[XW-1]
            && (mx[XW-2:0] < (XW-1)'(cols_q)) && (mx[XW-2:0] < (XW-1)'(MAP_COLS))
            && (my[XW-2:0] < (XW-1)'(rows_q)) && (my[XW-2:0] < (XW-1)'(MAP_ROWS));
    raddr_w = 32'(my[XW-2:0]) * 32'(MAP_COLS) + 32'(mx[XW-2:0]);
    waddr_w = 32'(c_row_q) * 32'(MAP_COLS) + 32'(c_col_q);
    map_we  = c_valid_q && (c_type_q == rwhs_pkg::REQ_MAP_WRITE)
           && (32'(c_col_q) < 32'(MAP_COLS)) && (32'(c_row_q) < 32'(MAP_ROWS));
  end

  // reads and writes share this stage, so request order holds in the map
  logic door_rd;

  rwhs_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_door_map (
    .clk_i   (clk_i),
    .we_i    (clr_busy_q || map_we),
    .waddr_i (clr_busy_q ? clr_addr_q : waddr_w[AW-1:0]),
    .wdata_i (clr_busy_q ? 1'b0 : c_door_q),
    .raddr_i (raddr_w[AW-1:0]),
    .rdata_o (door_rd)
  );

  // stage d: map data arrives, side resolved
  logic                       d_valid_q, d_in_range_q;
  logic [rwhs_pkg::SUM_W-1:0] d_sq_q;
  rwhs_pkg::meta_t            d_meta_q, d_meta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else begin
      d_valid_q <= c_valid_q && (c_type_q == rwhs_pkg::REQ_RAY);
    end
  end

  always_ff @(posedge clk_i) begin
    d_sq_q        <= sq_sel;
    d_in_range_q  <= in_range;
    d_meta_q.x    <= rx;
    d_meta_q.y    <= ry;
    d_meta_q.ofs  <= ofs_c;
    d_meta_q.side <= side_c;
  end

  always_comb begin
    d_meta = d_meta_q;
    if (d_in_range_q && door_rd) begin
      d_meta.side = rwhs_pkg::SIDE_DOOR;
    end
  end

  logic                        s_valid;
  logic [rwhs_pkg::ROOT_W-1:0] s_root;
  rwhs_pkg::meta_t             s_meta;

  rwhs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid_q),
    .rad_i   (rwhs_pkg::RAD_W'(d_sq_q)),
    .meta_i  (d_meta),
    .valid_o (s_valid),
    .root_o  (s_root),
    .meta_o  (s_meta)
  );

  rwhs_pkg::result_t res_in, res_out;

  always_comb begin
    res_in.meta     = s_meta;
    res_in.hit_dist = s_root[rwhs_pkg::ROOT_W-1] ? '1 : s_root[rwhs_pkg::DIST_W-1:0];
  end

  rwhs_oq u_oq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_valid),
    .data_i  (res_in),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .data_o  (res_out)
  );

  assign hit_distance_o   = res_out.hit_dist;
  assign chosen_x_o       = res_out.meta.x;
  assign chosen_y_o       = res_out.meta.y;
  assign texture_offset_o = res_out.meta.ofs;
  assign wall_side_o      = res_out.meta.side;

endmodule
